[sv/rmbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmbs_pkg - shared types and constants of the repeated bit serializer
// Item op codes, configuration register indexes, reset values and widths.
// ----------------------------------------------------------------------------
package rmbs_pkg;

	// Pattern store depth, settled by the 5-bit byte index of a load item
	localparam int MAX_PATTERN_BYTES = 32;
	localparam int BYTE_IDX_W        = $clog2(MAX_PATTERN_BYTES);
	localparam int LEN_W             = 6;
	localparam int REPEAT_W          = 8;
	localparam int PAUSE_W           = 4;
	localparam int BIT_POS_W         = 4;

	localparam logic [LEN_W-1:0]    LENGTH_RESET = 6'd17;
	localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd10;
	localparam logic [PAUSE_W-1:0]  PAUSE_RESET  = 4'd4;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_REPEAT_COUNT   = 2'd1,
		REG_PAUSE_TICKS    = 2'd2
	} reg_idx_t;

endpackage
`default_nettype wire

[sv/repeated_msb_first_bit_serializer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// repeated_msb_first_bit_serializer_top - repeated MSB-first bit serializer
// Sends a stored byte pattern on one pin, one bit per tick item, with repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, byte_index, byte_value.
//   A load item writes one pattern byte, a start item rewinds to bit 7 of
//   byte 0 and loads the repeat count, a tick item advances the pin by one
//   bit, or one pause tick, or ends the pass. Every item yields exactly one
//   result transfer on the output channel (out_valid / out_stall) with the
//   pin level, busy flag and done flag as they stand after the item.
//   Configuration port (cfg_valid / cfg_ready, always ready) writes
//   pattern_length, repeat_count and pause_ticks; write it only when idle.
//   An accepted item is held in the input register; the state update and
//   result are then captured in the output register, which drives
//   out_valid and the result outputs.
//   Throughput: one item per cycle while the receiver does not stall; the
//   state update path (bit/byte counters plus one pattern byte select) is combinational.
//   Reset clears all counters, drops the pin low and restores the register
//   defaults (length 17, repeat 10, pause 4); pattern bytes are not cleared.
//   When the receiver stalls, the output register holds its result and the
//   input register fills; in_stall then rises until the output drains.
// ----------------------------------------------------------------------------
module repeated_msb_first_bit_serializer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// item input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [4:0] byte_index,
	input  wire logic [7:0] byte_value,
	// result output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            pin_level,
	output logic            busy_res,
	output logic            done_res,
	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int IDX_W = rmbs_pkg::BYTE_IDX_W;
	localparam int LEN_W = rmbs_pkg::LEN_W;
	localparam int BPW   = rmbs_pkg::BIT_POS_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(rmbs_pkg::MAX_PATTERN_BYTES);

	// Configuration registers
	logic [LEN_W-1:0]              pattern_length_q;
	logic [rmbs_pkg::REPEAT_W-1:0] repeat_count_q;
	logic [rmbs_pkg::PAUSE_W-1:0]  pause_ticks_q;

	// Sequencer state
	logic [7:0]                    pattern_store_q [rmbs_pkg::MAX_PATTERN_BYTES];
	logic [BPW-1:0]                bit_pos_q;
	logic [LEN_W-1:0]              byte_pos_q;
	logic [rmbs_pkg::REPEAT_W-1:0] repeats_left_q;
	logic [rmbs_pkg::PAUSE_W-1:0]  pause_left_q;
	logic                          sending_q;
	logic                          pin_q;

	// Input register
	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0]       val_s1;

	// Output register
	logic out_valid_s2;
	logic pin_s2;
	logic busy_s2;
	logic done_s2;

	// Handshake: the output register takes a result when empty or draining
	logic adv_s2;
	logic take_s1;
	assign adv_s2    = !out_valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s2;
	assign take_s1   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	logic proc;
	assign proc = valid_s1 && adv_s2;

	// Next-state logic for the item held in the input register
	logic [LEN_W-1:0]              len_eff;
	logic [BPW-1:0]                bit_cur;
	logic [LEN_W-1:0]              byte_cur;
	logic [7:0]                    rd_byte;
	logic [BPW-1:0]                bit_nx;
	logic [LEN_W-1:0]              byte_nx;
	logic [rmbs_pkg::REPEAT_W-1:0] repeats_nx;
	logic [rmbs_pkg::PAUSE_W-1:0]  pause_nx;
	logic                          sending_nx;
	logic                          pin_nx;
	logic                          done_nx;

	assign len_eff  = (pattern_length_q > MAX_LEN) ? MAX_LEN : pattern_length_q;
	// Wrap to the next byte once all eight bits of this one are out
	assign bit_cur  = (bit_pos_q >= BPW'(8)) ? '0 : bit_pos_q;
	assign byte_cur = (bit_pos_q >= BPW'(8)) ? byte_pos_q + LEN_W'(1) : byte_pos_q;
	assign rd_byte  = pattern_store_q[byte_cur[IDX_W-1:0]];

	always_comb begin
		bit_nx     = bit_pos_q;
		byte_nx    = byte_pos_q;
		repeats_nx = repeats_left_q;
		pause_nx   = pause_left_q;
		sending_nx = sending_q;
		pin_nx     = pin_q;
		done_nx    = 1'b0;
		unique case (op_s1)
			rmbs_pkg::OP_LOAD: begin
			end
			rmbs_pkg::OP_START: begin
				bit_nx     = '0;
				byte_nx    = '0;
				repeats_nx = repeat_count_q;
				pause_nx   = '0;
				sending_nx = 1'b1;
			end
			rmbs_pkg::OP_TICK: begin
				if (sending_q) begin
					if (pause_left_q != '0) begin
						// hold the pin low through the pause
						pause_nx = pause_left_q - rmbs_pkg::PAUSE_W'(1);
						pin_nx   = 1'b0;
					end else if (byte_cur >= len_eff) begin
						// pass over: drop the pin, rewind, repeat or finish
						pin_nx  = 1'b0;
						bit_nx  = '0;
						byte_nx = '0;
						if (repeats_left_q != '0) begin
							repeats_nx = repeats_left_q - rmbs_pkg::REPEAT_W'(1);
							pause_nx   = pause_ticks_q;
						end else begin
							sending_nx = 1'b0;
							done_nx    = 1'b1;
						end
					end else begin
						pin_nx  = rd_byte[3'd7 - bit_cur[2:0]];
						bit_nx  = bit_cur + BPW'(1);
						byte_nx = byte_cur;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= rmbs_pkg::LENGTH_RESET;
			repeat_count_q   <= rmbs_pkg::REPEAT_RESET;
			pause_ticks_q    <= rmbs_pkg::PAUSE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rmbs_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				rmbs_pkg::REG_REPEAT_COUNT:   repeat_count_q   <= cfg_data;
				rmbs_pkg::REG_PAUSE_TICKS:    pause_ticks_q    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: capture an item on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			op_s1  <= op;
			idx_s1 <= byte_index;
			val_s1 <= byte_value;
		end
	end

	// Pattern store: payload only, no reset
	always_ff @(posedge clk) begin
		if (proc && op_s1 == rmbs_pkg::OP_LOAD) begin
			pattern_store_q[idx_s1] <= val_s1;
		end
	end

	// Sequencer state: advance once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q      <= '0;
			byte_pos_q     <= '0;
			repeats_left_q <= '0;
			pause_left_q   <= '0;
			sending_q      <= 1'b0;
			pin_q          <= 1'b0;
		end else if (proc) begin
			bit_pos_q      <= bit_nx;
			byte_pos_q     <= byte_nx;
			repeats_left_q <= repeats_nx;
			pause_left_q   <= pause_nx;
			sending_q      <= sending_nx;
			pin_q          <= pin_nx;
		end
	end

	// Output register: hold the result while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			pin_s2  <= pin_nx;
			busy_s2 <= sending_nx;
			done_s2 <= done_nx;
		end
	end

	assign out_valid = out_valid_s2;
	assign pin_level = pin_s2;
	assign busy_res  = busy_s2;
	assign done_res  = done_s2;

	// Checks on the sequencer
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && done_s2 |-> !busy_s2)
		else $error("done reported while still busy");

	a_done_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && done_s2 |-> !pin_s2)
		else $error("pin not low at end of final pass");

	a_pause_only_sending: assert property (@(posedge clk) disable iff (!arst_n)
		pause_left_q != '0 |-> sending_q)
		else $error("pause pending while idle");

	a_bit_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q <= BPW'(8))
		else $error("bit position out of range");

	a_byte_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= MAX_LEN)
		else $error("byte position beyond pattern store");

endmodule
`default_nettype wire
